>>> rtl/gcrg_pkg.sv
// gcrg_pkg: shared constants, register indexes and the sine table helper for the
// ground collision recovery guard; used by gcrg_sine_rom and the top level
// no dependencies
`default_nettype none

package gcrg_pkg;

  // Q1.15 full scale and fixed recovery commands
  localparam logic [14:0]        Q15_ONE        = 15'd32767;
  localparam logic signed [15:0] PITCH_FULL_UP  = -16'sd32767;
  localparam logic signed [15:0] PITCH_GENTLE   = -16'sd6553;
  localparam logic signed [15:0] CMD_ZERO       = 16'sd0;

  // angle constants, centidegrees
  localparam logic [15:0] QUAD_ANGLE  = 16'd9000;
  localparam logic [15:0] HALF_ANGLE  = 16'd18000;
  localparam logic [15:0] THREE_QUAD  = 16'd27000;
  localparam logic [15:0] FULL_TURN   = 16'd36000;
  localparam logic [14:0] ROLL_STEEP  = 15'd9000;
  localparam logic [14:0] ROLL_BANKED = 15'd4500;

  // table index rounding and reciprocal of 9000 (exact floor for n < 2^26)
  localparam logic [31:0] IDX_ROUND  = 32'd4500;
  localparam int          IDX_SHIFT  = 40;
  localparam logic [31:0] RECIP_9000 = 32'((64'd1 << IDX_SHIFT) / 64'd9000 + 64'd1);

  // roll command rounding and reciprocal of 3000 (exact floor for n < 2^30)
  localparam logic [31:0] ROLL_ROUND = 32'd1500;
  localparam int          ROLL_SHIFT = 42;
  localparam logic [31:0] RECIP_3000 = 32'((64'd1 << ROLL_SHIFT) / 64'd3000 + 64'd1);

  // sink must exceed 1 m/s: 10 dm/s scaled by 32767
  localparam logic signed [30:0] SINK_LIMIT = 31'sd327670;

  // half pi in Q30 used to build the sine table
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ENGAGE_ALT  = 2'd0,
    REG_RELEASE_ALT = 2'd1,
    REG_FLOOR_ALT   = 2'd2,
    REG_ENGAGE_TIME = 2'd3
  } reg_idx_t;

  localparam logic [17:0] ENGAGE_ALT_RST  = 18'd10000;
  localparam logic [17:0] RELEASE_ALT_RST = 18'd16000;
  localparam logic [17:0] FLOOR_ALT_RST   = 18'd4498;
  localparam logic [7:0]  ENGAGE_TIME_RST = 8'd11;

  // taylor series term divisor (2k)(2k+1) for term k of the sine series
  function automatic longint unsigned taylor_div(input longint unsigned t,
                                                 input logic [3:0] k);
    case (k)
      4'd1:    return t / 64'd6;
      4'd2:    return t / 64'd20;
      4'd3:    return t / 64'd42;
      4'd4:    return t / 64'd72;
      4'd5:    return t / 64'd110;
      4'd6:    return t / 64'd156;
      4'd7:    return t / 64'd210;
      4'd8:    return t / 64'd272;
      default: return t;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> rtl/gcrg_sine_rom.sv
// gcrg_sine_rom: quarter-wave Q15 sine table with registered read, built at elaboration
// depends on gcrg_pkg (PI_HALF_Q30, taylor_div, Q15_ONE)
`default_nettype none

module gcrg_sine_rom #(
  parameter int DEPTH = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(DEPTH+1)-1:0]   addr,
  output logic      [14:0]                  data_r
);

  // entry i is sin(pi/2 * i / DEPTH) * 32767, integer taylor series in Q30
  function automatic logic [DEPTH:0][14:0] build_rom();
    logic [DEPTH:0][14:0] rom;
    longint unsigned      x;
    longint unsigned      x2;
    longint unsigned      term;
    longint unsigned      v;
    longint               sum;
    for (int i = 0; i <= DEPTH; i++) begin
      x    = (gcrg_pkg::PI_HALF_Q30 * 64'(i)) / DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 8; k++) begin
        term = (term * x2) >> 30;
        term = gcrg_pkg::taylor_div(term, 4'(k));
        if (k[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'(gcrg_pkg::Q15_ONE)) begin
        v = 64'(gcrg_pkg::Q15_ONE);
      end
      rom[i] = 15'(v);
    end
    return rom;
  endfunction

  localparam logic [DEPTH:0][14:0] ROM = build_rom();

  // registered table read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_r <= ROM[addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/gcrg_mul.sv
// gcrg_mul: shared signed 32x32 multiplier with registered product
// no package dependencies
`default_nettype none

module gcrg_mul (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic      signed [63:0] prod_r
);

  // one product per enabled cycle
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ground_collision_recovery_guard.sv
// ground_collision_recovery_guard: low altitude recovery override, sequencer and datapath
// depends on gcrg_pkg, gcrg_mul (shared multiplier) and gcrg_sine_rom (sine table)
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------------
//   in       | in_valid / in_ready    | altitude, roll, pitch, speed, sticks, throttle
//   out      | out_valid / out_ready  | recovery_active, roll/pitch/rudder cmd, throttle
//   config   | APB psel/penable/...   | four limit registers at byte address 4*index
//
// each transaction passes from the accept state through eight sequencer steps before the next
// acceptance, set by the single multiplier doing seven products in turn (table index, divide by
// 9000, roll scale, divide by 3000, sink, time, height).
// rst_n is synchronous; it clears the recovery flag, the sequencer, the output valid and
// loads the limit registers with their defaults. no clearing pass is needed.
// the last step waits while the output register still holds an untaken result.
`default_nettype none

module ground_collision_recovery_guard #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [18:0] in_altitude_dm,
  input  wire logic signed [16:0] in_roll_cdeg,
  input  wire logic signed [14:0] in_pitch_cdeg,
  input  wire logic        [13:0] in_speed_dms,
  input  wire logic signed [15:0] in_stick_roll_in,
  input  wire logic signed [15:0] in_stick_pitch_in,
  input  wire logic signed [15:0] in_stick_rudder_in,
  input  wire logic        [14:0] in_throttle_in,

  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_recovery_active,
  output logic signed [15:0]      out_roll_cmd,
  output logic signed [15:0]      out_pitch_cmd,
  output logic signed [15:0]      out_rudder_cmd,
  output logic        [14:0]      out_throttle_out,

  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_IDX  = 9'b000000010,
    ST_DIV  = 9'b000000100,
    ST_ROLL = 9'b000001000,
    ST_RDIV = 9'b000010000,
    ST_SINK = 9'b000100000,
    ST_TP   = 9'b001000000,
    ST_HT   = 9'b010000000,
    ST_FIN  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [17:0] engage_alt_r;
  logic [17:0] release_alt_r;
  logic [17:0] floor_alt_r;
  logic [7:0]  engage_time_r;
  logic        cfg_wr;
  gcrg_pkg::reg_idx_t cfg_idx;

  // latched transaction and precomputed angle terms
  logic signed [18:0] alt_r;
  logic        [13:0] speed_r;
  logic signed [15:0] stick_roll_r;
  logic signed [15:0] stick_pitch_r;
  logic signed [15:0] stick_rudder_r;
  logic        [14:0] throttle_r;
  logic        [13:0] rp_r;
  logic               neg_r;
  logic        [14:0] abs_roll_r;
  logic               roll_pos_r;

  // working registers
  logic signed [15:0] rc_r;
  logic signed [30:0] p_r;
  logic signed [39:0] tp_r;
  logic               avoid_r;

  // output register
  logic               out_valid_r;
  logic               out_active_r;
  logic signed [15:0] out_roll_r;
  logic signed [15:0] out_pitch_r;
  logic signed [15:0] out_rudder_r;
  logic        [14:0] out_throttle_r;

  // shared units
  logic               mul_en;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod_r;
  logic               rom_en;
  logic        [14:0] sine_q;

  // combinational helpers
  logic        [15:0] pitch_mod;
  logic        [15:0] pitch_rem;
  logic        [1:0]  quad;
  logic        [13:0] rp_in;
  logic signed [17:0] roll_ext;
  logic signed [17:0] roll_norm;
  logic        [17:0] mag;
  logic        [14:0] mag_c;
  logic signed [19:0] alt_ext;
  logic signed [19:0] height;
  logic signed [39:0] ht;
  logic               danger;
  logic               release_ok;
  logic               avoid_nxt;
  logic               out_load;
  logic signed [15:0] pc;
  logic signed [31:0] sine_s;

  gcrg_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  gcrg_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk    (clk),
    .rd_en  (rom_en),
    .addr   (prod_r[gcrg_pkg::IDX_SHIFT +: IDX_W]),
    .data_r (sine_q)
  );

  // apb register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = gcrg_pkg::reg_idx_t'(paddr[3:2]);

  always_comb begin
    unique case (cfg_idx)
      gcrg_pkg::REG_ENGAGE_ALT:  prdata = {14'd0, engage_alt_r};
      gcrg_pkg::REG_RELEASE_ALT: prdata = {14'd0, release_alt_r};
      gcrg_pkg::REG_FLOOR_ALT:   prdata = {14'd0, floor_alt_r};
      gcrg_pkg::REG_ENGAGE_TIME: prdata = {24'd0, engage_time_r};
      default:                   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      engage_alt_r  <= gcrg_pkg::ENGAGE_ALT_RST;
      release_alt_r <= gcrg_pkg::RELEASE_ALT_RST;
      floor_alt_r   <= gcrg_pkg::FLOOR_ALT_RST;
      engage_time_r <= gcrg_pkg::ENGAGE_TIME_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        gcrg_pkg::REG_ENGAGE_ALT:  engage_alt_r  <= pwdata[17:0];
        gcrg_pkg::REG_RELEASE_ALT: release_alt_r <= pwdata[17:0];
        gcrg_pkg::REG_FLOOR_ALT:   floor_alt_r   <= pwdata[17:0];
        gcrg_pkg::REG_ENGAGE_TIME: engage_time_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // pitch reduced to quadrant and folded remainder
  always_comb begin
    if (in_pitch_cdeg[14]) begin
      pitch_mod = 16'({in_pitch_cdeg[14], in_pitch_cdeg}) + gcrg_pkg::FULL_TURN;
    end else begin
      pitch_mod = {1'b0, in_pitch_cdeg};
    end
    if (pitch_mod < gcrg_pkg::QUAD_ANGLE) begin
      quad      = 2'd0;
      pitch_rem = pitch_mod;
    end else if (pitch_mod < gcrg_pkg::HALF_ANGLE) begin
      quad      = 2'd1;
      pitch_rem = pitch_mod - gcrg_pkg::QUAD_ANGLE;
    end else if (pitch_mod < gcrg_pkg::THREE_QUAD) begin
      quad      = 2'd2;
      pitch_rem = pitch_mod - gcrg_pkg::HALF_ANGLE;
    end else begin
      quad      = 2'd3;
      pitch_rem = pitch_mod - gcrg_pkg::THREE_QUAD;
    end
    if (quad[0]) begin
      rp_in = 14'(gcrg_pkg::QUAD_ANGLE - pitch_rem);
    end else begin
      rp_in = pitch_rem[13:0];
    end
  end

  // roll normalized into +-180 degrees
  always_comb begin
    roll_ext = {in_roll_cdeg[16], in_roll_cdeg};
    if (roll_ext > 18'sd54000) begin
      roll_norm = roll_ext - 18'sd72000;
    end else if (roll_ext > 18'sd18000) begin
      roll_norm = roll_ext - 18'sd36000;
    end else if (roll_ext < -18'sd54000) begin
      roll_norm = roll_ext + 18'sd72000;
    end else if (roll_ext < -18'sd18000) begin
      roll_norm = roll_ext + 18'sd36000;
    end else begin
      roll_norm = roll_ext;
    end
  end

  // shared multiplier operand selection
  always_comb begin
    mul_en = 1'b0;
    mul_a  = 32'sd0;
    mul_b  = 32'sd0;
    rom_en = 1'b0;
    sine_s = neg_r ? $signed({17'd0, sine_q}) : -$signed({17'd0, sine_q});
    height = alt_ext - $signed({2'd0, floor_alt_r});
    unique case (state_r)
      ST_IDX: begin
        mul_en = 1'b1;
        mul_a  = $signed({18'd0, rp_r});
        mul_b  = 32'(SINE_TABLE_DEPTH);
      end
      ST_DIV: begin
        mul_en = 1'b1;
        mul_a  = $signed(prod_r[31:0] + gcrg_pkg::IDX_ROUND);
        mul_b  = $signed(gcrg_pkg::RECIP_9000);
      end
      ST_ROLL: begin
        mul_en = 1'b1;
        rom_en = 1'b1;
        mul_a  = $signed({17'd0, abs_roll_r});
        mul_b  = $signed({17'd0, gcrg_pkg::Q15_ONE});
      end
      ST_RDIV: begin
        mul_en = 1'b1;
        mul_a  = $signed(prod_r[31:0] + gcrg_pkg::ROLL_ROUND);
        mul_b  = $signed(gcrg_pkg::RECIP_3000);
      end
      ST_SINK: begin
        mul_en = 1'b1;
        mul_a  = $signed({18'd0, speed_r});
        mul_b  = sine_s;
      end
      ST_TP: begin
        mul_en = 1'b1;
        mul_a  = $signed({24'd0, engage_time_r});
        mul_b  = prod_r[31:0];
      end
      ST_HT: begin
        mul_en = 1'b1;
        mul_a  = {{12{height[19]}}, height};
        mul_b  = $signed({17'd0, gcrg_pkg::Q15_ONE});
      end
      default: ;
    endcase
  end

  // roll command magnitude and clamp
  assign mag   = prod_r[gcrg_pkg::ROLL_SHIFT +: 18];
  assign mag_c = (mag > {3'd0, gcrg_pkg::Q15_ONE}) ? gcrg_pkg::Q15_ONE : mag[14:0];

  // danger and release decision
  assign alt_ext    = {alt_r[18], alt_r};
  assign ht         = prod_r[39:0];
  assign danger     = (alt_ext < $signed({2'd0, engage_alt_r})) ||
                      ((p_r > gcrg_pkg::SINK_LIMIT) && (ht < tp_r));
  assign release_ok = (alt_ext > $signed({2'd0, release_alt_r})) && (p_r <= 31'sd0);
  assign avoid_nxt  = danger ? 1'b1 : (release_ok ? 1'b0 : avoid_r);

  always_comb begin
    if (abs_roll_r > gcrg_pkg::ROLL_STEEP) begin
      pc = gcrg_pkg::CMD_ZERO;
    end else if (abs_roll_r > gcrg_pkg::ROLL_BANKED) begin
      pc = gcrg_pkg::PITCH_GENTLE;
    end else begin
      pc = gcrg_pkg::PITCH_FULL_UP;
    end
  end

  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_IDX;
      ST_IDX:  state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_ROLL;
      ST_ROLL: state_nxt = ST_RDIV;
      ST_RDIV: state_nxt = ST_SINK;
      ST_SINK: state_nxt = ST_TP;
      ST_TP:   state_nxt = ST_HT;
      ST_HT:   state_nxt = ST_FIN;
      ST_FIN:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      avoid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        avoid_r <= avoid_nxt;
      end
    end
  end

  // transaction capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      alt_r          <= in_altitude_dm;
      speed_r        <= in_speed_dms;
      stick_roll_r   <= in_stick_roll_in;
      stick_pitch_r  <= in_stick_pitch_in;
      stick_rudder_r <= in_stick_rudder_in;
      throttle_r     <= in_throttle_in;
      rp_r           <= rp_in;
      neg_r          <= quad[1];
      abs_roll_r     <= roll_norm[17] ? 15'(-roll_norm) : roll_norm[14:0];
      roll_pos_r     <= (roll_norm > 18'sd0);
    end
  end

  // intermediate results
  always_ff @(posedge clk) begin
    if (state_r == ST_SINK) begin
      rc_r <= roll_pos_r ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
    end
    if (state_r == ST_TP) begin
      p_r <= prod_r[30:0];
    end
    if (state_r == ST_HT) begin
      tp_r <= prod_r[39:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_active_r <= avoid_nxt;
      if (avoid_nxt) begin
        out_roll_r     <= rc_r;
        out_pitch_r    <= pc;
        out_rudder_r   <= gcrg_pkg::CMD_ZERO;
        out_throttle_r <= gcrg_pkg::Q15_ONE;
      end else begin
        out_roll_r     <= stick_roll_r;
        out_pitch_r    <= stick_pitch_r;
        out_rudder_r   <= stick_rudder_r;
        out_throttle_r <= throttle_r;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_recovery_active = out_active_r;
  assign out_roll_cmd        = out_roll_r;
  assign out_pitch_cmd       = out_pitch_r;
  assign out_rudder_cmd      = out_rudder_r;
  assign out_throttle_out    = out_throttle_r;

  // accepted transaction starts the sequencer
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_IDX)
    else $error("sequencer did not start after accept");

  // finishing step fills the output register and frees the input
  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == ST_IDLE)
    else $error("result not loaded at end of sequence");

  // recovery override drives full throttle and centered rudder
  a_override_cmds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_active_r |->
      out_throttle_r == gcrg_pkg::Q15_ONE && out_rudder_r == gcrg_pkg::CMD_ZERO)
    else $error("recovery commands wrong");

  // roll command stays inside the clamp
  a_roll_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_active_r |-> out_roll_r != -16'sd32768)
    else $error("roll command outside clamp");

endmodule

`default_nettype wire
